>>> src/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types, sizes and codes of the slot packet ring FIFO.
// ----------------------------------------------------------------------------
package spr_pkg;

	// Ring geometry
	localparam int SLOTS      = 16;
	localparam int SLOT_BYTES = 64;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BYTE_W     = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
	localparam int ADDR_W     = $clog2(SLOTS * SLOT_BYTES);
	localparam int CNT_W      = $clog2(SLOTS + 1);

	// Field widths
	localparam int LEN_W  = 7;
	localparam int BYTE_D = 8;
	localparam int FLAG_W = 8;
	localparam int FD_W   = 16;
	localparam int META_W = LEN_W + FLAG_W;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// Input op codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_PEEK  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_DROP_FULL = 2'd1;
	localparam logic [1:0] ST_DROP_SIZE = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_READ,
		CMD_PEEK
	} cmd_kind_t;

	typedef enum logic [1:0] {
		DROP_NONE,
		DROP_FULL,
		DROP_SIZE
	} drop_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_META,
		BK_RD_REQ,
		BK_RD_DATA
	} back_state_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [BYTE_D-1:0]  data;
		logic [FLAG_W-1:0]  flags;
		logic               last;
	} cmd_t;

	// Queue handshake toward the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

	typedef struct packed {
		logic [BYTE_D-1:0] out_byte;
		logic [LEN_W-1:0]  length;
		logic [FLAG_W-1:0] out_flags;
		logic [1:0]        status;
		logic              end_of_run;
		logic [FD_W-1:0]   full_drops;
	} result_t;

	// Payload address of a byte within a slot
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
			input logic [BYTE_W-1:0] b);
		return ADDR_W'(s) * ADDR_W'(SLOT_BYTES) + ADDR_W'(b);
	endfunction

endpackage

>>> src/spr_ram.sv
// ----------------------------------------------------------------------------
// spr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/spr_front.sv
// ----------------------------------------------------------------------------
// spr_front
// Accepts input items, classifies the op and queues commands for the back end.
// ----------------------------------------------------------------------------
module spr_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                op,
	input  logic [spr_pkg::BYTE_D-1:0] data_byte,
	input  logic [spr_pkg::FLAG_W-1:0] pkt_flags,
	input  logic                      last,
	output spr_pkg::queue_head_t      head,
	input  logic                      pop
);
	import spr_pkg::*;

	cmd_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	cmd_t              cmd;
	logic              known;
	logic              accept;
	logic              push;
	logic              do_pop;

	// Classify the op; the undefined code is accepted and dropped
	always_comb begin
		cmd.data  = data_byte;
		cmd.flags = pkt_flags;
		cmd.last  = last;
		known     = 1'b1;
		unique case (op)
			OP_WRITE: cmd.kind = CMD_WRITE;
			OP_READ:  cmd.kind = CMD_READ;
			OP_PEEK:  cmd.kind = CMD_PEEK;
			default: begin
				cmd.kind = CMD_WRITE;
				known    = 1'b0;
			end
		endcase
	end

	assign in_stall   = (cnt_q == QCNT_W'(QDEPTH));
	assign accept     = in_valid && !in_stall;
	assign push       = accept && known;
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = ent_q[rptr_q];
	assign do_pop     = pop && head.valid;

	// Store queued commands
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("command queue overfilled");

	a_full_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == QCNT_W'(QDEPTH)) && !do_pop |=> (cnt_q == QCNT_W'(QDEPTH)))
		else $error("command queue lost an entry while full");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !do_pop)
		else $error("pop from empty command queue");

endmodule

>>> src/spr_back.sv
// ----------------------------------------------------------------------------
// spr_back
// Executes queued commands against the slot ring and drives the result register.
// ----------------------------------------------------------------------------
module spr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spr_pkg::queue_head_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output spr_pkg::result_t     res
);
	import spr_pkg::*;

	back_state_t       state_q;
	back_state_t       state_d;
	logic [SLOT_W-1:0] ws_q;
	logic [SLOT_W-1:0] rs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [LEN_W-1:0]  bip_q;
	drop_t             drop_q;
	logic [FD_W-1:0]   fd_q;
	logic [BYTE_W-1:0] idx_q;
	cmd_kind_t         kind_q;
	logic              out_valid_q;
	result_t           res_q;

	logic              out_free;
	logic              full_now;
	drop_t             drop_eff;
	logic [LEN_W-1:0]  bip_inc;
	logic              do_write;
	logic              commit;
	logic              meta_re;
	logic              pay_we;
	logic              pay_re;
	logic              emit;
	result_t           emit_res;
	logic              rd_last;
	logic              rd_done;
	logic [META_W-1:0] meta_rdata;
	logic [LEN_W-1:0]  meta_len;
	logic [FLAG_W-1:0] meta_flags;
	logic [BYTE_D-1:0] pay_rdata;

	assign out_free   = !out_valid_q || !out_stall;
	assign meta_len   = meta_rdata[META_W-1:FLAG_W];
	assign meta_flags = meta_rdata[FLAG_W-1:0];
	assign rd_last    = ((LEN_W'(idx_q) + 1'b1) == meta_len);

	// Occupied slots are always rs..ws-1, so the fill count tells full and empty
	assign full_now = (cnt_q == CNT_W'(SLOTS));

	// Resolve the drop decision for the byte at the queue head
	always_comb begin
		drop_eff = drop_q;
		if (drop_eff == DROP_NONE && bip_q == '0 && full_now) begin
			drop_eff = DROP_FULL;
		end
		if (drop_eff == DROP_NONE && bip_q >= LEN_W'(SLOT_BYTES)) begin
			drop_eff = DROP_SIZE;
		end
		bip_inc = (bip_q < LEN_W'(SLOT_BYTES)) ? bip_q + 1'b1 : bip_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid && head.cmd.kind != CMD_WRITE) begin
					state_d = BK_META;
				end
			end
			BK_META: begin
				if (cnt_q == '0 || kind_q == CMD_PEEK) begin
					if (out_free) begin
						state_d = BK_IDLE;
					end
				end else begin
					state_d = BK_RD_REQ;
				end
			end
			BK_RD_REQ: state_d = BK_RD_DATA;
			BK_RD_DATA: begin
				if (out_free) begin
					state_d = rd_last ? BK_IDLE : BK_RD_REQ;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Control and result selection
	always_comb begin
		pop      = 1'b0;
		do_write = 1'b0;
		commit   = 1'b0;
		meta_re  = 1'b0;
		pay_re   = 1'b0;
		emit     = 1'b0;
		rd_done  = 1'b0;
		emit_res = '{out_byte: '0, length: '0, out_flags: '0, status: ST_OK,
			end_of_run: 1'b1, full_drops: fd_q};
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					if (head.cmd.kind == CMD_WRITE) begin
						if (!head.cmd.last || out_free) begin
							pop      = 1'b1;
							do_write = 1'b1;
						end
					end else begin
						pop     = 1'b1;
						meta_re = 1'b1;
					end
				end
				if (do_write && head.cmd.last) begin
					emit = 1'b1;
					case (drop_eff)
						DROP_FULL: begin
							emit_res.status     = ST_DROP_FULL;
							emit_res.full_drops = fd_q + 1'b1;
						end
						DROP_SIZE: emit_res.status = ST_DROP_SIZE;
						default: begin
							commit             = 1'b1;
							emit_res.length    = bip_inc;
							emit_res.out_flags = head.cmd.flags;
						end
					endcase
				end
			end
			BK_META: begin
				if (cnt_q == '0) begin
					emit            = out_free;
					emit_res.status = ST_EMPTY;
				end else if (kind_q == CMD_PEEK) begin
					emit               = out_free;
					emit_res.length    = meta_len;
					emit_res.out_flags = meta_flags;
				end
			end
			BK_RD_REQ: pay_re = 1'b1;
			BK_RD_DATA: begin
				emit                = out_free;
				rd_done             = out_free && rd_last;
				emit_res.out_byte   = pay_rdata;
				emit_res.length     = meta_len;
				emit_res.out_flags  = meta_flags;
				emit_res.end_of_run = rd_last;
			end
			default: ;
		endcase
	end

	assign pay_we = do_write && (drop_eff == DROP_NONE);

	// Sequencer and ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			ws_q        <= '0;
			rs_q        <= '0;
			cnt_q       <= '0;
			bip_q       <= '0;
			drop_q      <= DROP_NONE;
			fd_q        <= '0;
			idx_q       <= '0;
			kind_q      <= CMD_READ;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (meta_re) begin
				kind_q <= head.cmd.kind;
			end
			// Track the packet being written
			if (do_write) begin
				if (head.cmd.last) begin
					bip_q  <= '0;
					drop_q <= DROP_NONE;
					if (drop_eff == DROP_FULL) begin
						fd_q <= fd_q + 1'b1;
					end
				end else begin
					bip_q  <= bip_inc;
					drop_q <= drop_eff;
				end
			end
			if (commit) begin
				ws_q  <= (ws_q == SLOT_W'(SLOTS - 1)) ? '0 : ws_q + 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
			// Step through the head packet
			if (state_q == BK_META) begin
				idx_q <= '0;
			end else if (state_q == BK_RD_DATA && out_free && !rd_last) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rd_done) begin
				rs_q  <= (rs_q == SLOT_W'(SLOTS - 1)) ? '0 : rs_q + 1'b1;
				cnt_q <= cnt_q - 1'b1;
			end
			// Hold or load the result register
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_res;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	// Length and flags of every slot, written on commit, read at the head
	spr_ram #(
		.WIDTH(META_W),
		.DEPTH(SLOTS)
	) u_meta_ram (
		.clk  (clk),
		.we   (commit),
		.waddr(ws_q),
		.wdata({bip_inc, head.cmd.flags}),
		.re   (meta_re),
		.raddr(rs_q),
		.rdata(meta_rdata)
	);

	// Payload bytes of all slots
	spr_ram #(
		.WIDTH(BYTE_D),
		.DEPTH(SLOTS * SLOT_BYTES)
	) u_pay_ram (
		.clk  (clk),
		.we   (pay_we),
		.waddr(slot_addr(ws_q, bip_q[BYTE_W-1:0])),
		.wdata(head.cmd.data),
		.re   (pay_re),
		.raddr(slot_addr(rs_q, idx_q)),
		.rdata(pay_rdata)
	);

	a_commit_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (cnt_q < CNT_W'(SLOTS)))
		else $error("commit into a full ring");

	a_stream_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_RD_DATA) |-> (cnt_q != '0 && meta_len != '0))
		else $error("streaming from an empty slot");

	a_mid_result_stream: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !emit_res.end_of_run |-> (state_q == BK_RD_DATA))
		else $error("non-final result outside a packet read");

	a_empty_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (ws_q == rs_q))
		else $error("ring pointers disagree with fill count");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwrote a waiting result");

endmodule

>>> src/slot_packet_ring_fifo.sv
// ----------------------------------------------------------------------------
// slot_packet_ring_fifo
// Ring of fixed-size packet slots with byte-wise write, streamed read and peek.
// ----------------------------------------------------------------------------
// A write byte reaches the back end through a two-entry command queue; the
// last byte of a packet gives one result with the commit or drop status. A
// peek does a registered read of the slot length and flags. A read does that
// lookup, then for each payload byte a registered read of the payload RAM
// ahead of the result register; an empty ring gives one empty result.
// Results wait in an output register, so the queue keeps taking items while
// the consumer stalls, until the queue is full.
// The ring state needs no clearing pass after reset: the fill count marks
// which slots hold packets.
module slot_packet_ring_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 op,
	input  logic [spr_pkg::BYTE_D-1:0] data_byte,
	input  logic [spr_pkg::FLAG_W-1:0] pkt_flags,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [spr_pkg::BYTE_D-1:0] out_byte,
	output logic [spr_pkg::LEN_W-1:0]  length,
	output logic [spr_pkg::FLAG_W-1:0] out_flags,
	output logic [1:0]                 status,
	output logic                       end_of_run,
	output logic [spr_pkg::FD_W-1:0]   full_drops
);
	import spr_pkg::*;

	queue_head_t head;
	logic        pop;
	result_t     res;

	// Accept and classify items
	spr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.data_byte(data_byte),
		.pkt_flags(pkt_flags),
		.last     (last),
		.head     (head),
		.pop      (pop)
	);

	// Execute commands against the ring
	spr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res      (res)
	);

	assign out_byte   = res.out_byte;
	assign length     = res.length;
	assign out_flags  = res.out_flags;
	assign status     = res.status;
	assign end_of_run = res.end_of_run;
	assign full_drops = res.full_drops;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the slot packet ring FIFO. Writes packets byte by
// byte, reads and peeks the head, and checks every result against a predictor
// of the slot ring that runs on each accepted item.
// ----------------------------------------------------------------------------
module tb;
	import spr_pkg::*;

	// Unused op code: the block ignores it
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          op = OP_WRITE;
	logic [BYTE_D-1:0]   data_byte = '0;
	logic [FLAG_W-1:0]   pkt_flags = '0;
	logic                last = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [BYTE_D-1:0]   out_byte;
	logic [LEN_W-1:0]    length;
	logic [FLAG_W-1:0]   out_flags;
	logic [1:0]          status;
	logic                end_of_run;
	logic [FD_W-1:0]     full_drops;

	slot_packet_ring_fifo uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.data_byte  (data_byte),
		.pkt_flags  (pkt_flags),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.length     (length),
		.out_flags  (out_flags),
		.status     (status),
		.end_of_run (end_of_run),
		.full_drops (full_drops)
	);

	// Ring state as the predictor sees it
	logic [LEN_W-1:0]  ring_len [SLOTS];
	logic [FLAG_W-1:0] ring_flags [SLOTS];
	logic [BYTE_D-1:0] ring_payload [SLOTS][SLOT_BYTES];
	logic [SLOT_W-1:0] wr_slot;
	logic [SLOT_W-1:0] rd_slot;
	logic [LEN_W-1:0]  pkt_bytes;
	drop_t             pkt_drop;
	logic [FD_W-1:0]   full_drop_cnt;

	result_t pending_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int items_sent = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int commits = 0;
	int full_drop_pkts = 0;
	int size_drop_pkts = 0;
	int stream_reads = 0;
	int cycle_count = 0;

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void queue_result(input logic [BYTE_D-1:0] b, input logic [LEN_W-1:0] len,
			input logic [FLAG_W-1:0] fl, input logic [1:0] st, input logic eor);
		result_t r;
		r.out_byte   = b;
		r.length     = len;
		r.out_flags  = fl;
		r.status     = st;
		r.end_of_run = eor;
		r.full_drops = full_drop_cnt;
		pending_results.push_back(r);
	endfunction

	// Advance the ring state by one accepted item and queue its results
	function automatic void predict_ring_op(input logic [1:0] op_i, input logic [BYTE_D-1:0] data_i,
			input logic [FLAG_W-1:0] flags_i, input logic last_i);
		logic [LEN_W-1:0] len;
		if (op_i == OP_WRITE) begin
			// full check on the first byte, size check on every byte
			if (pkt_drop == DROP_NONE && pkt_bytes == 0 && ring_len[wr_slot] != 0)
				pkt_drop = DROP_FULL;
			if (pkt_drop == DROP_NONE && pkt_bytes >= SLOT_BYTES)
				pkt_drop = DROP_SIZE;
			if (pkt_drop == DROP_NONE)
				ring_payload[wr_slot][pkt_bytes] = data_i;
			if (pkt_bytes < SLOT_BYTES)
				pkt_bytes++;
			if (last_i) begin
				case (pkt_drop)
					DROP_FULL: begin
						full_drop_cnt++;
						full_drop_pkts++;
						queue_result('0, '0, '0, ST_DROP_FULL, 1'b1);
					end
					DROP_SIZE: begin
						size_drop_pkts++;
						queue_result('0, '0, '0, ST_DROP_SIZE, 1'b1);
					end
					default: begin
						ring_len[wr_slot] = pkt_bytes;
						ring_flags[wr_slot] = flags_i;
						commits++;
						queue_result('0, pkt_bytes, flags_i, ST_OK, 1'b1);
						wr_slot++;
					end
				endcase
				pkt_bytes = '0;
				pkt_drop = DROP_NONE;
			end
		end else if (op_i == OP_READ || op_i == OP_PEEK) begin
			len = ring_len[rd_slot];
			if (len == 0) begin
				queue_result('0, '0, '0, ST_EMPTY, 1'b1);
			end else if (op_i == OP_PEEK) begin
				queue_result('0, len, ring_flags[rd_slot], ST_OK, 1'b1);
			end else begin
				// stream the head packet, then free its slot
				for (int i = 0; i < len; i++)
					queue_result(ring_payload[rd_slot][i], len, ring_flags[rd_slot], ST_OK,
						i == len - 1);
				stream_reads++;
				ring_len[rd_slot] = '0;
				rd_slot++;
			end
		end
	endfunction

	// Send one item, with random idle cycles ahead of it
	task automatic send_item(input logic [1:0] op_i, input logic [BYTE_D-1:0] data_i,
			input logic [FLAG_W-1:0] flags_i, input logic last_i);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= op_i;
		data_byte <= data_i;
		pkt_flags <= flags_i;
		last <= last_i;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_ring_op(op_i, data_i, flags_i, last_i);
		if (op_i != OP_UNUSED)
			items_sent++;
	endtask

	// Write a whole packet of random bytes
	task automatic send_packet(input int len, input logic [FLAG_W-1:0] flags_i);
		for (int i = 0; i < len; i++)
			send_item(OP_WRITE, BYTE_D'($urandom), (i == len - 1) ? flags_i : FLAG_W'($urandom),
				i == len - 1);
	endtask

	function automatic void check_field(input string name, input logic [FD_W-1:0] want,
			input logic [FD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Drive the receiver stall and check each accepted result
	always @(posedge clk) begin
		result_t want;
		cycle_count++;
		out_stall <= ($urandom_range(99) < recv_idle_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no item pending: byte %0d length %0d status %0d",
					out_byte, length, status);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				check_field("out_byte", want.out_byte, out_byte);
				check_field("length", want.length, length);
				check_field("out_flags", want.out_flags, out_flags);
				check_field("status", want.status, status);
				check_field("end_of_run", want.end_of_run, end_of_run);
				check_field("full_drops", want.full_drops, full_drops);
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Read and peek on an empty ring, and unused ops
	task automatic test_empty_ring();
		send_item(OP_READ, '0, '0, 1'b0);
		send_item(OP_PEEK, '1, '1, 1'b1);
		send_item(OP_UNUSED, '1, '1, 1'b1);
		send_item(OP_UNUSED, '0, '0, 1'b0);
		send_item(OP_PEEK, '0, '0, 1'b0);
	endtask

	// One-byte and two-byte packets with extreme bytes and flags
	task automatic test_packet_extremes();
		send_item(OP_WRITE, 8'h00, 8'h00, 1'b1);
		send_item(OP_WRITE, 8'hFF, 8'h00, 1'b0);
		send_item(OP_WRITE, 8'hFF, 8'hFF, 1'b1);
		send_item(OP_PEEK, '0, '0, 1'b0);
		send_item(OP_READ, '0, '0, 1'b0);
		send_item(OP_PEEK, '0, '0, 1'b0);
		send_item(OP_READ, '0, '0, 1'b0);
		send_item(OP_READ, '0, '0, 1'b0);
	endtask

	// Largest packet that fits, then an oversize packet
	task automatic test_size_limits();
		send_packet(SLOT_BYTES, 8'hA5);
		send_item(OP_PEEK, '0, '0, 1'b0);
		send_item(OP_READ, '0, '0, 1'b0);
		send_packet(SLOT_BYTES + 1, 8'h5A);
		send_item(OP_READ, '0, '0, 1'b0);
	endtask

	// Fill the ring, drop for full, free a slot mid-packet, drain
	task automatic test_ring_full();
		for (int i = 0; i < SLOTS; i++)
			send_packet(1 + (i % 3), FLAG_W'(i));
		send_packet(2, 8'h11);
		// drop stays in force though a slot frees during the packet
		send_item(OP_WRITE, BYTE_D'($urandom), '0, 1'b0);
		send_item(OP_READ, '0, '0, 1'b0);
		send_item(OP_WRITE, BYTE_D'($urandom), 8'h22, 1'b1);
		send_item(OP_PEEK, '0, '0, 1'b0);
		// refill the freed slot, then full drop wins over oversize
		send_packet(1, 8'h33);
		send_packet(SLOT_BYTES + 2, 8'h44);
		for (int i = 0; i <= SLOTS; i++)
			send_item(OP_READ, '0, '0, 1'b0);
	endtask

	// Reads and peeks while a packet is still arriving
	task automatic test_read_during_write();
		send_item(OP_WRITE, BYTE_D'($urandom), '0, 1'b0);
		send_item(OP_PEEK, '0, '0, 1'b0);
		send_item(OP_WRITE, BYTE_D'($urandom), '0, 1'b0);
		send_item(OP_READ, '0, '0, 1'b0);
		send_item(OP_WRITE, BYTE_D'($urandom), 8'h81, 1'b1);
		send_packet(2, 8'h7E);
		send_item(OP_WRITE, BYTE_D'($urandom), '0, 1'b0);
		send_item(OP_READ, '0, '0, 1'b0);
		send_item(OP_WRITE, BYTE_D'($urandom), 8'h18, 1'b1);
		send_item(OP_READ, '0, '0, 1'b0);
		send_item(OP_READ, '0, '0, 1'b0);
	endtask

	// Random packets, reads and peeks, some slipped in mid-packet
	task automatic test_random_traffic(input int target);
		int start_count;
		int pick;
		int len;
		logic [FLAG_W-1:0] flags_r;
		start_count = items_sent;
		while (items_sent - start_count < target) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				pick = $urandom_range(99);
				if (pick < 60)
					len = $urandom_range(1, 3);
				else if (pick < 96)
					len = $urandom_range(4, 12);
				else
					len = $urandom_range(SLOT_BYTES - 4, SLOT_BYTES + 2);
				flags_r = FLAG_W'($urandom);
				for (int i = 0; i < len; i++) begin
					send_item(OP_WRITE, BYTE_D'($urandom),
						(i == len - 1) ? flags_r : FLAG_W'($urandom), i == len - 1);
					if (i < len - 1 && $urandom_range(99) < 6)
						send_item($urandom_range(1) ? OP_READ : OP_PEEK, BYTE_D'($urandom),
							FLAG_W'($urandom), 1'($urandom));
				end
			end else if (pick < 82) begin
				send_item(OP_READ, BYTE_D'($urandom), FLAG_W'($urandom), 1'($urandom));
			end else if (pick < 96) begin
				send_item(OP_PEEK, BYTE_D'($urandom), FLAG_W'($urandom), 1'($urandom));
			end else begin
				send_item(OP_UNUSED, BYTE_D'($urandom), FLAG_W'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		int directed_items;
		for (int i = 0; i < SLOTS; i++) begin
			ring_len[i] = '0;
			ring_flags[i] = '0;
		end
		wr_slot = '0;
		rd_slot = '0;
		pkt_bytes = '0;
		pkt_drop = DROP_NONE;
		full_drop_cnt = '0;

		// hold reset, then release on an edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver heavily
		send_idle_pct = 30;
		recv_idle_pct = 73;
		test_empty_ring();
		test_packet_extremes();
		test_size_limits();
		test_ring_full();
		test_read_during_write();
		directed_items = items_sent;
		test_random_traffic(10);

		// swap the idle pressure
		send_idle_pct = 73;
		recv_idle_pct = 30;
		test_random_traffic(20);

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(20);

		// drop valid right after the last accepted item
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items (%0d directed), checked %0d results", items_sent,
			directed_items, results_checked);
		$display("commits %0d, streamed reads %0d, full drops %0d, oversize drops %0d",
			commits, stream_reads, full_drop_pkts, size_drop_pkts);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
